### rtl/md_pkg.sv
package md_pkg;

    localparam int unsigned SYM_W      = 8;
    localparam int unsigned CHAR_W     = 8;
    localparam int unsigned CODE_W     = 8;
    localparam int unsigned COUNT_W    = 3;

    localparam logic [COUNT_W-1:0] MAX_SYMBOLS = 3'd5;

    localparam logic [SYM_W-1:0] SYM_DOT  = 8'h2E;  // '.'
    localparam logic [SYM_W-1:0] SYM_DASH = 8'h2D;  // '-'

    // Result of a code lookup: hit flag and ASCII character.
    typedef struct packed {
        logic              found;
        logic [CHAR_W-1:0] character;
    } lookup_t;

    // Base-3 weight of symbol position k: 3^k.
    function automatic logic [CODE_W-1:0] symbol_weight(input logic [COUNT_W-1:0] pos);
        logic [CODE_W-1:0] w;
        unique case (pos)
            3'd0:    w = 8'd1;
            3'd1:    w = 8'd3;
            3'd2:    w = 8'd9;
            3'd3:    w = 8'd27;
            3'd4:    w = 8'd81;
            default: w = 8'd0;
        endcase
        return w;
    endfunction

    // Code to character ROM, a-z then 0-9.
    function automatic lookup_t code_lookup(input logic [CODE_W-1:0] code);
        lookup_t r;
        r.found = 1'b1;
        unique case (code)
            8'd7:    r.character = "a";
            8'd41:   r.character = "b";
            8'd50:   r.character = "c";
            8'd14:   r.character = "d";
            8'd1:    r.character = "e";
            8'd49:   r.character = "f";
            8'd17:   r.character = "g";
            8'd40:   r.character = "h";
            8'd4:    r.character = "i";
            8'd79:   r.character = "j";
            8'd23:   r.character = "k";
            8'd43:   r.character = "l";
            8'd8:    r.character = "m";
            8'd5:    r.character = "n";
            8'd26:   r.character = "o";
            8'd52:   r.character = "p";
            8'd71:   r.character = "q";
            8'd16:   r.character = "r";
            8'd13:   r.character = "s";
            8'd2:    r.character = "t";
            8'd22:   r.character = "u";
            8'd67:   r.character = "v";
            8'd25:   r.character = "w";
            8'd68:   r.character = "x";
            8'd77:   r.character = "y";
            8'd44:   r.character = "z";
            8'd242:  r.character = "0";
            8'd241:  r.character = "1";
            8'd238:  r.character = "2";
            8'd229:  r.character = "3";
            8'd202:  r.character = "4";
            8'd121:  r.character = "5";
            8'd122:  r.character = "6";
            8'd125:  r.character = "7";
            8'd134:  r.character = "8";
            8'd161:  r.character = "9";
            default:
            begin
                r.found     = 1'b0;
                r.character = '0;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/md_if.sv
// Input channel: one Morse byte per transfer.
interface md_in_if;
    import md_pkg::*;

    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] symbol;
    logic             last;

    modport source (output valid, output symbol, output last, input ready);
    modport sink   (input valid, input symbol, input last, output ready);
endinterface

// Output channel: one decoded character or separator per transfer.
interface md_out_if;
    import md_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] character;
    logic              unknown;
    logic              final_res;

    modport source (output valid, output character, output unknown, output final_res,
                    input ready);
    modport sink   (input valid, input character, input unknown, input final_res,
                    output ready);
endinterface

### rtl/morse_decoder.sv
// Channel  Dir  Payload                          Handshake
// din      in   symbol[7:0], last                valid/ready
// dout     out  character[7:0], unknown, final   valid/ready
//
// One byte per cycle when dout does not stall: the letter state and the result
// register update in the same cycle the byte is taken; a result appears on dout
// the cycle after. The figure is set by one add of a base-3 weight plus a 36-entry ROM compare.
// Reset (rst_n, async, active low) clears the pending letter and dout.valid.
// din.ready stays high while dout is empty or being drained, so a stalled
// result holds in the output register and blocks only further transfers.
module morse_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    md_in_if.sink      din,
    md_out_if.source   dout
);
    import md_pkg::*;

    // Pending letter state
    logic [CODE_W-1:0]  code_reg,  code_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               too_long_reg, too_long_next;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]  character_reg, character_next;
    logic               unknown_reg,   unknown_next;
    logic               final_reg,     final_next;

    logic               accept;
    logic               is_symbol;
    logic               is_dash;
    logic               has_room;
    logic               has_result;
    logic [CODE_W-1:0]  weight;
    logic [CODE_W-1:0]  code_add;
    logic [COUNT_W-1:0] count_add;
    logic               too_long_add;
    logic [CODE_W-1:0]  flush_code;
    logic               flush_too_long;
    logic               pending;
    lookup_t            hit;

    assign din.ready = !out_valid_reg || dout.ready;
    assign accept    = din.valid && din.ready;

    assign is_dash   = (din.symbol == SYM_DASH);
    assign is_symbol = (din.symbol == SYM_DOT) || is_dash;
    assign has_room  = (count_reg < MAX_SYMBOLS);

    // Accumulate: dot adds w, dash adds 2w; a sixth symbol only marks overflow.
    assign weight = symbol_weight(count_reg);

    always_comb
    begin
        if (is_symbol && has_room)
        begin
            code_add     = code_reg + (is_dash ? {weight[CODE_W-2:0], 1'b0} : weight);
            count_add    = count_reg + 1'b1;
            too_long_add = too_long_reg;
        end
        else
        begin
            code_add     = code_reg;
            count_add    = count_reg;
            too_long_add = too_long_reg | is_symbol;
        end
    end

    // A separator always gives a result; a symbol only when it is the last.
    assign has_result = !is_symbol || din.last;

    // Symbols flush the updated letter; separators flush what was already there.
    assign flush_code     = is_symbol ? code_add : code_reg;
    assign flush_too_long = is_symbol ? too_long_add : too_long_reg;
    assign pending        = is_symbol || (count_reg != '0);

    assign hit = code_lookup(flush_code);

    always_comb
    begin
        code_next     = code_reg;
        count_next    = count_reg;
        too_long_next = too_long_reg;
        if (accept)
        begin
            if (has_result)
            begin
                code_next     = '0;
                count_next    = '0;
                too_long_next = 1'b0;
            end
            else
            begin
                code_next     = code_add;
                count_next    = count_add;
                too_long_next = too_long_add;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        character_next = character_reg;
        unknown_next   = unknown_reg;
        final_next     = final_reg;
        if (dout.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept && has_result)
        begin
            out_valid_next = 1'b1;
            final_next     = din.last;
            if (pending)
            begin
                // Overlong letters and codes missing from the ROM give NUL.
                if (flush_too_long || !hit.found)
                begin
                    character_next = '0;
                    unknown_next   = 1'b1;
                end
                else
                begin
                    character_next = hit.character;
                    unknown_next   = 1'b0;
                end
            end
            else
            begin
                // Nothing pending: pass the separator through.
                character_next = din.symbol;
                unknown_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg      <= '0;
            count_reg     <= '0;
            too_long_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            code_reg      <= code_next;
            count_reg     <= count_next;
            too_long_reg  <= too_long_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        character_reg <= character_next;
        unknown_reg   <= unknown_next;
        final_reg     <= final_next;
    end

    assign dout.valid     = out_valid_reg;
    assign dout.character = character_reg;
    assign dout.unknown   = unknown_reg;
    assign dout.final_res = final_reg;

    // Checks

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_SYMBOLS)
        else $error("symbol count beyond five");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        too_long_reg |-> (count_reg == MAX_SYMBOLS))
        else $error("overflow flag set on a short letter");

    a_result_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && has_result) |=> (count_reg == '0 && code_reg == '0 && !too_long_reg))
        else $error("letter state not cleared after a result");

    a_unknown_nul: assert property (@(posedge clk) disable iff (!rst_n)
        (dout.valid && dout.unknown) |-> (dout.character == '0))
        else $error("unknown result carries a character");

endmodule
